[sv/gdp_pkg.sv]
// shared types and constants for the gradient dither pixel core
package gdp_pkg;

    localparam int unsigned NUM_CH = 3;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_239 = 25'd17970575;

    localparam logic [10:0] DITHER_BIAS = 11'd3;
    localparam logic [2:0]  DITHER_K [NUM_CH] = '{3'd0, 3'd3, 3'd5};

    typedef logic [7:0]  t_row;
    typedef logic [9:0]  t_col;
    typedef logic [15:0] t_color;
    typedef logic [7:0]  t_chan;

    typedef enum logic [0:0] {
        REG_START_COLOR = 1'b0,
        REG_END_COLOR   = 1'b1
    } t_reg_idx;

endpackage

[sv/gdp_if.sv]
// valid/ready channels for the pixel request and the pixel word
interface gdp_req_if;
    import gdp_pkg::*;

    logic valid;
    logic ready;
    t_row row;
    t_col column_offset;

    modport source (output valid, output row, output column_offset, input ready);
    modport sink   (input valid, input row, input column_offset, output ready);
endinterface

interface gdp_rsp_if;
    import gdp_pkg::*;

    logic   valid;
    logic   ready;
    t_color pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

[sv/gradient_dither_pixel_core.sv]
// vertical gradient with ordered dither, one rgb565 pixel word per request
//
// i_req carries the screen row and the column offset inside the rectangle;
// o_rsp returns the dithered rgb565 pixel word. both are valid/ready channels.
// the two gradient end colors are written through the apb port: start_color
// at byte 0, end_color at byte 4; pready is tied high and reads return them.
// the datapath is a four-register pipeline: input register, |delta|*row,
// reciprocal multiply for the divide by 239, then dither, clamp and pack
// into the output register. one request is taken per cycle unless o_rsp stalls.
// each stage loads whenever it is empty or its successor loads, so a stall
// on o_rsp holds the output word and fills the stages behind it one by one
// before i_req.ready drops; bubbles are squeezed out.
// synchronous active-low reset empties the pipeline and clears both colors
// to black.
module gradient_dither_pixel_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gdp_req_if.sink                       i_req,
    gdp_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gdp_pkg::ADDR_W-1:0]    paddr,
    input  logic [gdp_pkg::DATA_W-1:0]    pwdata,
    output logic [gdp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import gdp_pkg::*;

    t_color   r_start;
    t_color   r_end;
    t_reg_idx reg_idx;
    logic     wr_en;

    logic [3:0] r_vld;
    logic [3:0] rdy;

    t_row       r_row;
    logic [2:0] r_phase;

    logic [15:0] r_mag  [NUM_CH];
    logic [15:0] n_mag  [NUM_CH];
    logic        r_neg  [NUM_CH];
    logic        n_neg  [NUM_CH];
    t_chan       r_base [NUM_CH];
    t_chan       n_base [NUM_CH];
    logic [2:0]  r_dsum;

    logic [8:0]  r_q     [NUM_CH];
    logic [8:0]  n_q     [NUM_CH];
    logic        r_neg2  [NUM_CH];
    t_chan       r_base2 [NUM_CH];
    logic [2:0]  r_dsum2;

    t_chan  fin [NUM_CH];
    t_color r_pixel;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_COLOR: r_start <= pwdata[15:0];
                REG_END_COLOR:   r_end   <= pwdata[15:0];
                default:         r_start <= r_start;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_COLOR: prdata = {16'd0, r_start};
            REG_END_COLOR:   prdata = {16'd0, r_end};
            default:         prdata = '0;
        endcase
    end

    // stage enables
    assign rdy[3] = !r_vld[3] | o_rsp.ready;
    assign rdy[2] = !r_vld[2] | rdy[3];
    assign rdy[1] = !r_vld[1] | rdy[2];
    assign rdy[0] = !r_vld[0] | rdy[1];

    assign i_req.ready = rdy[0];
    assign o_rsp.valid = r_vld[3];
    assign o_rsp.pixel = r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_req.valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // stage 1: expand colors, |delta| * row
    always_comb begin
        t_chan a [NUM_CH];
        t_chan b [NUM_CH];
        a[0] = {r_start[15:11], 3'd0};
        a[1] = {r_start[10:5],  2'd0};
        a[2] = {r_start[4:0],   3'd0};
        b[0] = {r_end[15:11],   3'd0};
        b[1] = {r_end[10:5],    2'd0};
        b[2] = {r_end[4:0],     3'd0};
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_neg[ch]  = b[ch] < a[ch];
            n_base[ch] = a[ch];
            n_mag[ch]  = (n_neg[ch] ? {8'd0, a[ch] - b[ch]} : {8'd0, b[ch] - a[ch]})
                         * {8'd0, r_row};
        end
    end

    // stage 2: divide by 239 through the reciprocal
    always_comb begin
        logic [RECIP_SHIFT+8:0] prod;
        prod = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            prod    = {25'd0, r_mag[ch]} * {16'd0, RECIP_239};
            n_q[ch] = prod[RECIP_SHIFT+8:RECIP_SHIFT];
        end
    end

    // stage 3: add dither, clamp
    always_comb begin
        logic [2:0]  ph;
        logic [10:0] off;
        logic [10:0] sq;
        logic [10:0] v;
        ph  = '0;
        off = '0;
        sq  = '0;
        v   = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            ph  = r_dsum2 + DITHER_K[ch];
            off = {8'd0, ph} - DITHER_BIAS;
            sq  = r_neg2[ch] ? (11'd0 - {2'd0, r_q[ch]}) : {2'd0, r_q[ch]};
            v   = {3'd0, r_base2[ch]} + sq + off;
            if (v[10]) begin
                fin[ch] = 8'd0;
            end else if (v[9:8] != 2'd0) begin
                fin[ch] = 8'd255;
            end else begin
                fin[ch] = v[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_row   <= i_req.row;
            r_phase <= i_req.column_offset[2:0];
        end
        if (rdy[1]) begin
            r_mag  <= n_mag;
            r_neg  <= n_neg;
            r_base <= n_base;
            r_dsum <= r_phase + r_row[2:0];
        end
        if (rdy[2]) begin
            r_q     <= n_q;
            r_neg2  <= r_neg;
            r_base2 <= r_base;
            r_dsum2 <= r_dsum;
        end
        if (rdy[3]) begin
            r_pixel <= {fin[0][7:3], fin[1][7:2], fin[2][7:3]};
        end
    end

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_rsp.valid)
        else $error("output valid after reset");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_vld[0])
        else $error("accepted request not captured");

    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_q[0] <= 9'd268 && r_q[1] <= 9'd268 && r_q[2] <= 9'd268))
        else $error("blend quotient out of range");

    a_stall_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_vld == 4'hf && !o_rsp.ready))
        else $error("request stalled with room in pipeline");
`endif

endmodule

[bench/tb.sv]
// self-checking bench for gradient_dither_pixel_core: random requests, apb setup, predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gdp_pkg::*;

    localparam int LAST_ROW    = 239;
    localparam int CHAN_TOP    = 255;
    localparam int DITHER_OFS  = 3;
    localparam int DITHER_SPAN = 8;
    localparam int K_RED       = 0;
    localparam int K_GREEN     = 3;
    localparam int K_BLUE      = 5;
    localparam int IDLE_PCT    = 24;
    localparam int DRAIN       = 12;
    localparam int LIMIT       = 200000;

    typedef struct packed {
        t_row row;
        t_col col;
    } t_pixel_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    gdp_req_if req_if ();
    gdp_rsp_if rsp_if ();

    gradient_dither_pixel_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_pixel_req pixel_req_q[$];
    t_color     pixel_due[$];
    t_color     start_q = '0;
    t_color     end_q = '0;
    bit         calm = 1'b0;
    int         mismatches = 0;
    int         words_checked = 0;
    int         settings_run = 0;
    int         cycles = 0;

    always #5 i_clk = ~i_clk;

    task automatic report(string what);
        $display("tb: mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    function automatic int dithered_channel(int lo, int hi, int row, int phase, int k);
        int v;
        v = lo + ((hi - lo) * row) / LAST_ROW;
        v = v + (phase + row + k) % DITHER_SPAN - DITHER_OFS;
        if (v < 0) begin
            v = 0;
        end
        if (v > CHAN_TOP) begin
            v = CHAN_TOP;
        end
        return v;
    endfunction

    function automatic t_color gradient_pixel(t_row row, t_col col);
        int r;
        int g;
        int b;
        int y;
        int ph;
        y  = int'(row);
        ph = int'(col[2:0]);
        r = dithered_channel(int'(start_q[15:11]) << 3, int'(end_q[15:11]) << 3, y, ph, K_RED);
        g = dithered_channel(int'(start_q[10:5]) << 2, int'(end_q[10:5]) << 2, y, ph, K_GREEN);
        b = dithered_channel(int'(start_q[4:0]) << 3, int'(end_q[4:0]) << 3, y, ph, K_BLUE);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                pixel_due.push_back(gradient_pixel(req_if.row, req_if.column_offset));
            end
            if (!req_if.valid || req_if.ready) begin
                if (pixel_req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    t_pixel_req nxt;
                    nxt = pixel_req_q.pop_front();
                    req_if.row           <= nxt.row;
                    req_if.column_offset <= nxt.col;
                    req_if.valid         <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // pixel word monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pixel_due.size() == 0) begin
                    report($sformatf("unexpected pixel word %h", rsp_if.pixel));
                end else begin
                    t_color want;
                    want = pixel_due.pop_front();
                    words_checked++;
                    if (rsp_if.pixel !== want) begin
                        report($sformatf("pixel %h, expected %h", rsp_if.pixel, want));
                    end
                end
            end
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    // sampled on the falling edge so the driver's updates have landed
    task automatic settle();
        @(negedge i_clk);
        while (pixel_req_q.size() != 0 || pixel_due.size() != 0 || req_if.valid) begin
            @(negedge i_clk);
        end
    endtask

    task automatic apb_write(t_reg_idx idx, t_color value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(t_reg_idx idx, t_color value);
        logic [DATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(int'(idx) * 4);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {16'h0, value}) begin
            report($sformatf("register %s reads %h, expected %h", idx.name(), got, value));
        end
    endtask

    task automatic run_phase(t_color lo, t_color hi, bit load, int n, bit directed);
        t_row       corner_rows[8];
        t_pixel_req item;
        corner_rows = '{8'd0, 8'd1, 8'd119, 8'd238, 8'd239, 8'd240, 8'd254, 8'd255};
        settle();
        if (load) begin
            apb_write(REG_START_COLOR, lo);
            apb_write(REG_END_COLOR, hi);
            start_q = lo;
            end_q   = hi;
        end
        apb_check(REG_START_COLOR, start_q);
        apb_check(REG_END_COLOR, end_q);
        settings_run++;
        for (int i = 0; i < n; i++) begin
            if (directed) begin
                item.row = corner_rows[i % 8];
                item.col = {7'($urandom_range(127)), 3'(i)};
                if (i == 0) begin
                    item.col = '0;
                end else if (i == 1) begin
                    item.col = '1;
                end
            end else begin
                if ($urandom_range(3) == 0) begin
                    item.row = t_row'($urandom_range(255, 232));
                end else begin
                    item.row = t_row'($urandom_range(255));
                end
                item.col = t_col'($urandom_range(1023));
            end
            pixel_req_q.push_back(item);
        end
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.row = '0;
        req_if.column_offset = '0;
        rsp_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(16'h0000, 16'h0000, 1'b0, 20, 1'b0);
        run_phase(16'h0000, 16'hFFFF, 1'b1, 24, 1'b1);
        run_phase(16'hFFFF, 16'h0000, 1'b1, 80, 1'b0);
        run_phase(16'h8410, 16'h8410, 1'b1, 60, 1'b0);
        run_phase(16'hF800, 16'h001F, 1'b1, 80, 1'b0);
        for (int p = 0; p < 6; p++) begin
            settle();
            calm = (p == 2);
            run_phase(t_color'($urandom_range(65535)), t_color'($urandom_range(65535)),
                      1'b1, 100, 1'b0);
        end
        settle();
        calm = 1'b0;
        repeat (DRAIN) @(posedge i_clk);

        $display("tb: %0d pixel words checked over %0d color settings", words_checked,
                 settings_run);
        $display("tb: rows 0..255 with all dither phases, incl. extrapolation and equal colors");
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/gdp_pkg.sv
sv/gdp_if.sv
sv/gradient_dither_pixel_core.sv
bench/tb.sv
